[hw/rtl/ggc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared widths and the CORDIC arctangent table for the go-to-goal controller.
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC datapath: x/y grow to about 2^33.3, angle in Q16 radians
  localparam int XW    = 36;
  localparam int ZW    = 20;
  localparam int OFS_W = 33;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);

  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(51472);
      5'd1:    v = ZW'(30386);
      5'd2:    v = ZW'(16055);
      5'd3:    v = ZW'(8150);
      5'd4:    v = ZW'(4091);
      5'd5:    v = ZW'(2047);
      5'd6:    v = ZW'(1024);
      5'd7:    v = ZW'(512);
      5'd8:    v = ZW'(256);
      5'd9:    v = ZW'(128);
      5'd10:   v = ZW'(64);
      5'd11:   v = ZW'(32);
      5'd12:   v = ZW'(16);
      5'd13:   v = ZW'(8);
      5'd14:   v = ZW'(4);
      5'd15:   v = ZW'(2);
      5'd16:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/ggc_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_cordic
// Iterative CORDIC vectoring unit: quarter-turn pre-rotation, then one
// shift-add step per cycle on a single shared adder set.
// ----------------------------------------------------------------------------
module ggc_cordic #(
  parameter int CORDIC_STEPS = ggc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ggc_pkg::OFS_W-1:0]  dx,
  input  logic signed [ggc_pkg::OFS_W-1:0]  dy,
  output logic                              done,
  output logic signed [ggc_pkg::XW-1:0]     x_out,
  output logic signed [ggc_pkg::ZW-1:0]     z_out
);
  import ggc_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t               state_r;
  logic [CW-1:0]         iter_r;
  logic                  done_r;
  logic signed [XW-1:0]  x_r;
  logic signed [XW-1:0]  y_r;
  logic signed [ZW-1:0]  z_r;

  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;
  logic signed [ZW-1:0]  ang;

  assign xs  = x_r >>> iter_r;
  assign ys  = y_r >>> iter_r;
  assign ang = $signed(atan_q16(5'(iter_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      iter_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            iter_r  <= '0;
            state_r <= C_RUN;
            if (dx < 0) begin
              if (dy >= 0) begin
                x_r <= XW'(dy);
                y_r <= -XW'(dx);
                z_r <= HALF_PI_Q16;
              end else begin
                x_r <= -XW'(dy);
                y_r <= XW'(dx);
                z_r <= -HALF_PI_Q16;
              end
            end else begin
              x_r <= XW'(dx);
              y_r <= XW'(dy);
              z_r <= '0;
            end
          end
        end
        C_RUN: begin
          if (y_r >= 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + ang;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - ang;
          end
          if (iter_r == CW'(CORDIC_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= C_IDLE;
          end else begin
            iter_r <= iter_r + 1'b1;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

[hw/rtl/go_to_goal_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_controller_top
// Go-to-goal proportional drive controller for a unicycle robot.
//
// Input words carry a command in in_tuser (tick, start, cancel) and the
// measured pose in in_tdata. Each input word yields exactly one output word
// with the linear speed and turn rate in out_tdata and the status in
// out_tuser. Goal, arrival tolerance and both gains are written through the
// cfg_ port; the user must write them only while the block is idle, which
// the block itself does not enforce. Start and cancel words, and ticks while
// disarmed, go straight to the output stage. An armed tick runs the CORDIC
// vectoring unit, then the shared multiplier for distance scaling and both
// gains. One word is in work at a time; in_tready is high only while the
// sequencer idles.
// Reset disarms the block and loads the default tolerance and gains.
// A stalled receiver holds the result in the output register; the next word
// may be accepted meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module go_to_goal_controller_top #(
  parameter int CORDIC_STEPS = ggc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ggc_pkg::IN_DATA_W-1:0]       in_tdata,   // pos_x, pos_y, heading
  input  logic [ggc_pkg::CMD_W-1:0]           in_tuser,   // cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ggc_pkg::OUT_DATA_W-1:0]      out_tdata,  // linear_speed, turn_rate
  output logic [ggc_pkg::ST_W-1:0]            out_tuser,  // status
  input  logic                                cfg_we,
  input  logic [ggc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ggc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ggc_pkg::*;

  localparam int LO_W = 18;
  localparam int HI_W = XW - 1 - LO_W;
  localparam int KW   = 24;
  localparam int BW   = KW + 1;
  localparam int PW   = XW + BW;
  localparam int AW   = LO_W + KW;
  localparam int SW   = HI_W + KW + LO_W + 2;
  localparam int DW   = 34;
  localparam int LSW  = DW + 17;
  localparam int EW   = 18;
  localparam int ZW1  = ZW + 1;

  localparam logic [KW-1:0]          INV_GAIN_Q24 = KW'(10188014);
  localparam logic signed [EW-1:0]   PI_Q13       = EW'(25736);
  localparam logic signed [EW-1:0]   TWO_PI_Q13   = EW'(51472);
  localparam logic signed [PW-1:0]   TURN_MAX     = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0]   TURN_MIN     = PW'(-64'sh8000_0000);

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_GAIN = 3'd4;

  typedef enum logic [1:0] {CMD_TICK, CMD_START, CMD_CANCEL} cmd_t;
  typedef enum logic [1:0] {ST_IDLE, ST_DRIVING, ST_REACHED, ST_CANCELED} status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_CORD, S_MLO, S_MHI, S_DIST, S_CMP, S_MANG, S_TURN, S_DONE
  } state_t;

  state_t                 state_r;
  logic                   armed_r;

  logic signed [31:0]     goal_x_r;
  logic signed [31:0]     goal_y_r;
  logic [30:0]            tol_r;
  logic [15:0]            lin_gain_r;
  logic [15:0]            ang_gain_r;

  logic signed [OFS_W-1:0] dx_r;
  logic signed [OFS_W-1:0] dy_r;
  logic signed [15:0]      hd_r;
  logic                    zero_r;

  logic signed [PW-1:0]   prod_r;
  logic [AW-1:0]          acc_r;
  logic [DW-1:0]          dist_r;
  logic signed [EW-1:0]   err_r;

  logic [31:0]            lin_r;
  logic [31:0]            turn_r;
  status_t                st_r;

  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic [ST_W-1:0]        out_tuser_r;

  logic signed [31:0]     pos_x;
  logic signed [31:0]     pos_y;
  logic signed [15:0]     heading;
  cmd_t                   cmd;
  logic                   in_fire;

  logic                   cord_start;
  logic                   cord_done;
  logic signed [XW-1:0]   cx;
  logic signed [ZW-1:0]   cz;

  logic [XW-2:0]          ux;
  logic signed [ZW1-1:0]  zr;
  logic signed [ZW1-1:0]  bear;
  logic signed [XW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic [SW-1:0]          dsum;
  logic [LSW-1:0]         lsum;
  logic [LSW-9:0]         lin_q;
  logic signed [PW-1:0]   tsum;
  logic signed [PW-1:0]   tq;
  logic                   out_free;

  assign pos_x   = $signed(in_tdata[31:0]);
  assign pos_y   = $signed(in_tdata[63:32]);
  assign heading = $signed(in_tdata[79:64]);
  assign cmd     = cmd_t'(in_tuser);

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cord_start = (state_r == S_START);
  assign out_free   = !out_tvalid_r || out_tready;

  ggc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .done  (cord_done),
    .x_out (cx),
    .z_out (cz)
  );

  assign ux   = (cx > 0) ? cx[XW-2:0] : '0;
  assign zr   = ZW1'(cz) + ZW1'(4);
  assign bear = zr >>> 3;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MLO: begin
        mul_a = $signed(XW'(ux[LO_W-1:0]));
        mul_b = $signed(BW'(INV_GAIN_Q24));
      end
      S_MHI: begin
        mul_a = $signed(XW'(ux[XW-2:LO_W]));
        mul_b = $signed(BW'(INV_GAIN_Q24));
      end
      S_CMP: begin
        mul_a = $signed(XW'(dist_r));
        mul_b = $signed(BW'(lin_gain_r));
      end
      S_MANG: begin
        mul_a = XW'(err_r);
        mul_b = $signed(BW'(ang_gain_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dsum  = SW'(acc_r) + (SW'(prod_r[HI_W+KW-1:0]) << LO_W) + (SW'(1) << 23);
  assign lsum  = LSW'(prod_r[DW+15:0]) + LSW'(128);
  assign lin_q = lsum[LSW-1:8];
  assign tsum  = prod_r + PW'(16);
  assign tq    = tsum >>> 5;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= '0;
      goal_y_r   <= '0;
      tol_r      <= 31'd6554;
      lin_gain_r <= 16'd128;
      ang_gain_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:   goal_x_r   <= $signed(cfg_data);
        REG_GOAL_Y:   goal_y_r   <= $signed(cfg_data);
        REG_TOL:      tol_r      <= cfg_data[30:0];
        REG_LIN_GAIN: lin_gain_r <= cfg_data[15:0];
        REG_ANG_GAIN: ang_gain_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      armed_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            lin_r   <= '0;
            turn_r  <= '0;
            state_r <= S_DONE;
            case (cmd)
              CMD_START: begin
                armed_r <= 1'b1;
                st_r    <= ST_DRIVING;
              end
              CMD_CANCEL: begin
                armed_r <= 1'b0;
                st_r    <= armed_r ? ST_CANCELED : ST_IDLE;
              end
              CMD_TICK: begin
                st_r <= armed_r ? ST_DRIVING : ST_IDLE;
                if (armed_r) begin
                  dx_r    <= OFS_W'(goal_x_r) - OFS_W'(pos_x);
                  dy_r    <= OFS_W'(goal_y_r) - OFS_W'(pos_y);
                  hd_r    <= heading;
                  zero_r  <= (goal_x_r == pos_x) && (goal_y_r == pos_y);
                  state_r <= S_START;
                end
              end
              default: st_r <= armed_r ? ST_DRIVING : ST_IDLE;
            endcase
          end
        end
        S_START: state_r <= S_CORD;
        S_CORD: begin
          if (cord_done) begin
            state_r <= S_MLO;
          end
        end
        S_MLO: begin
          err_r   <= zero_r ? -EW'(hd_r) : EW'(bear) - EW'(hd_r);
          state_r <= S_MHI;
        end
        S_MHI: begin
          acc_r <= prod_r[AW-1:0];
          if (err_r > PI_Q13) begin
            err_r <= err_r - TWO_PI_Q13;
          end else if (err_r <= -PI_Q13) begin
            err_r <= err_r + TWO_PI_Q13;
          end
          state_r <= S_DIST;
        end
        S_DIST: begin
          dist_r  <= zero_r ? '0 : dsum[DW+23:24];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (dist_r < DW'(tol_r)) begin
            armed_r <= 1'b0;
            st_r    <= ST_REACHED;
            state_r <= S_DONE;
          end else begin
            state_r <= S_MANG;
          end
        end
        S_MANG: begin
          lin_r   <= (lin_q > (LSW-8)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : lin_q[31:0];
          state_r <= S_TURN;
        end
        S_TURN: begin
          if (tq > TURN_MAX) begin
            turn_r <= 32'h7FFF_FFFF;
          end else if (tq < TURN_MIN) begin
            turn_r <= 32'h8000_0000;
          end else begin
            turn_r <= tq[31:0];
          end
          st_r    <= ST_DRIVING;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {turn_r, lin_r};
            out_tuser_r  <= st_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
